/* hw/rtl/kst_pkg.sv */
`timescale 1ns / 1ps

package kst_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned RANK_W   = 7;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE
  } op_e;

  // What one cell shows its neighbours: whether it holds a value not above
  // the incoming one, and the value itself.
  typedef struct packed {
    logic                    le;
    logic signed [VAL_W-1:0] value;
  } link_t;

endpackage

/* hw/rtl/kst_in_if.sv */
`timescale 1ns / 1ps

interface kst_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [kst_pkg::VAL_W-1:0]  value;
  logic                              restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

/* hw/rtl/kst_out_if.sv */
`timescale 1ns / 1ps

interface kst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kst_pkg::VAL_W-1:0]  kth_value;
  logic [kst_pkg::CNT_W-1:0]         held_count;

  modport source (output valid, output kth_value, output held_count, input ready);
  modport sink   (input valid, input kth_value, input held_count, output ready);
endinterface

/* hw/rtl/kst_cell.sv */
`timescale 1ns / 1ps

module kst_cell (
  input  logic                             clk_i,
  input  logic [kst_pkg::IDX_W-1:0]        idx_i,
  input  logic [kst_pkg::CNT_W-1:0]        count_i,
  input  kst_pkg::op_e                     op_i,
  input  logic signed [kst_pkg::VAL_W-1:0] value_i,
  input  kst_pkg::link_t                   lower_i,
  input  kst_pkg::link_t                   upper_i,
  output kst_pkg::link_t                   link_o,
  output logic signed [kst_pkg::VAL_W-1:0] value_d_o
);

  logic signed [kst_pkg::VAL_W-1:0] value_q, value_d;
  logic                             valid;
  logic                             le;

  assign valid = {1'b0, idx_i} < count_i;
  assign le    = valid && (value_q <= value_i);

  // The row is kept in ascending order, smallest at index 0.
  always_comb begin
    value_d = value_q;
    unique case (op_i)
      kst_pkg::OP_INSERT: begin
        if (!le) begin
          value_d = lower_i.le ? value_i : lower_i.value;
        end
      end
      kst_pkg::OP_REPLACE: begin
        // The smallest leaves; values not above the incoming one move down one place.
        if (upper_i.le) begin
          value_d = upper_i.value;
        end else if (le) begin
          value_d = value_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o    = '{le: le, value: value_q};
  assign value_d_o = value_d;

endmodule

/* hw/rtl/kth_largest_stream_tracker_unit.sv */
`timescale 1ns / 1ps

// Tracks the k largest signed 32-bit values of a stream.
// Input channel in_i carries a value and a restart flag per beat; restart
// empties the kept set before the value is taken. Every input beat yields
// one output beat on out_o: the smallest kept value (the k-th largest once
// k values are held) and the number of values held.
// k is written through cfg_we_i / cfg_wdata_i, by the user only while the
// block is idle; the block does not enforce this. 0 acts as 1 and values
// above 64 act as 64. The kept values sit in a row of 64 cells in
// ascending order. Every cell compares the incoming value with its own in
// parallel and shifts by one place. One beat per cycle is sustained while
// in_i.ready is high; results are registered in the output or skid place.
// A two-deep output buffer lets one input beat be taken while a result is
// stalled; in_i.ready falls only when both buffer places are full.
// Reset empties the kept set, sets k to 1 and clears both output places.
module kth_largest_stream_tracker_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kst_in_if.sink                       in_i,
  kst_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [kst_pkg::RANK_W-1:0]   cfg_wdata_i
);

  localparam int unsigned N = kst_pkg::CAPACITY;

  logic [kst_pkg::RANK_W-1:0]        rank_q;
  logic [kst_pkg::CNT_W-1:0]         count_q, count_d, count_eff, k_eff;
  kst_pkg::op_e                      op;
  logic                              accept;
  kst_pkg::link_t                    link [N];
  logic signed [kst_pkg::VAL_W-1:0]  cell_d [N];
  logic signed [kst_pkg::VAL_W-1:0]  head_d;

  logic                              out_valid_q, skid_valid_q;
  logic signed [kst_pkg::VAL_W-1:0]  out_value_q, skid_value_q;
  logic [kst_pkg::CNT_W-1:0]         out_count_q, skid_count_q;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    if (rank_q == '0) begin
      k_eff = kst_pkg::CNT_W'(1);
    end else if ({{(32-kst_pkg::RANK_W){1'b0}}, rank_q} > N) begin
      k_eff = kst_pkg::CNT_W'(N);
    end else begin
      k_eff = kst_pkg::CNT_W'(rank_q);
    end
  end

  assign count_eff = in_i.restart ? '0 : count_q;

  always_comb begin
    op = kst_pkg::OP_HOLD;
    if (accept) begin
      priority if (count_eff < k_eff) begin
        op = kst_pkg::OP_INSERT;
      end else if (in_i.value > link[0].value) begin
        op = kst_pkg::OP_REPLACE;
      end else begin
        op = kst_pkg::OP_HOLD;
      end
    end
  end

  assign count_d = (op == kst_pkg::OP_INSERT) ? count_eff + 1'b1 : count_eff;

  assign head_d = cell_d[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    kst_pkg::link_t lower, upper;

    if (i == 0) begin : g_first
      assign lower = '{le: 1'b1, value: '0};
    end else begin : g_lower
      assign lower = link[i-1];
    end
    if (i == N - 1) begin : g_last
      assign upper = '{le: 1'b0, value: '0};
    end else begin : g_upper
      assign upper = link[i+1];
    end

    kst_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (kst_pkg::IDX_W'(i)),
      .count_i   (count_eff),
      .op_i      (op),
      .value_i   (in_i.value),
      .lower_i   (lower),
      .upper_i   (upper),
      .link_o    (link[i]),
      .value_d_o (cell_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= kst_pkg::RANK_W'(1);
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Output register with one skid place behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_o.ready) begin
      if (skid_valid_q) begin
        out_value_q <= skid_value_q;
        out_count_q <= skid_count_q;
      end else if (accept) begin
        out_value_q <= head_d;
        out_count_q <= count_d;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_value_q <= head_d;
        skid_count_q <= count_d;
      end else begin
        out_value_q <= head_d;
        out_count_q <= count_d;
      end
    end
  end

  assign in_i.ready       = !skid_valid_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.kth_value  = out_value_q;
  assign out_o.held_count = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kst_pkg::CNT_W'(N))
    else $error("held count above capacity");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid place full while output register empty");

  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.restart) |=> count_q == kst_pkg::CNT_W'(1))
    else $error("restart did not leave exactly one value");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.restart && count_q < k_eff) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the kept set");

  a_row_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= kst_pkg::CNT_W'(2) |-> link[0].value <= link[1].value)
    else $error("smallest two cells out of order");

endmodule

/* tb/kst_rank_checker.sv */
`timescale 1ns / 1ps

module kst_rank_checker
  import kst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  kst_in_if                 in_mon,
  kst_out_if                out_mon,
  input  logic              cfg_we_i,
  input  logic [RANK_W-1:0] cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] kth_value;
    logic [CNT_W-1:0]        held_count;
  } rank_report_t;

  // Kept values in ascending order, so the smallest is always at the front.
  logic signed [VAL_W-1:0] kept_q[$];
  rank_report_t            report_q[$];
  logic [RANK_W-1:0]       rank_reg;
  int                      mismatches;

  function automatic rank_report_t absorb(input logic signed [VAL_W-1:0] v,
                                          input logic rs);
    int           k;
    int           pos;
    rank_report_t rep;
    k = (rank_reg == 0) ? 1 : (rank_reg > CAPACITY) ? CAPACITY : int'(rank_reg);
    if (rs) kept_q.delete();
    // Once the rank has been lowered the set may hold more than k values; a
    // larger value then still displaces the smallest, and the count stays.
    if (kept_q.size() < k || (kept_q.size() > 0 && v > kept_q[0])) begin
      if (kept_q.size() >= k) void'(kept_q.pop_front());
      pos = 0;
      while (pos < kept_q.size() && kept_q[pos] < v) pos++;
      kept_q.insert(pos, v);
    end
    rep.kth_value  = kept_q[0];
    rep.held_count = CNT_W'(kept_q.size());
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rank_report_t want;
    if (!rst_ni) begin
      kept_q.delete();
      report_q.delete();
      rank_reg     = 1;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // The output side is handled first: a result never leaves in the
      // same beat as the input that caused it.
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result with none expected, actual kth_value %0d held_count %0d",
                   $time, out_mon.kth_value, out_mon.held_count);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (out_mon.kth_value !== want.kth_value) begin
            $display("%0t: kth_value mismatch, expected %0d, actual %0d",
                     $time, want.kth_value, out_mon.kth_value);
            mismatches++;
          end
          if (out_mon.held_count !== want.held_count) begin
            $display("%0t: held_count mismatch, expected %0d, actual %0d",
                     $time, want.held_count, out_mon.held_count);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        report_q.push_back(absorb(in_mon.value, in_mon.restart));
      if (cfg_we_i) rank_reg = cfg_wdata_i;
      fail_count_o <= mismatches;
      pending_o    <= report_q.size();
    end
  end

endmodule

/* tb/kth_largest_stream_tracker_unit_tb.sv */
`timescale 1ns / 1ps

module kth_largest_stream_tracker_unit_tb;
  import kst_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 600;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic              clk_i;
  logic              rst_n;
  logic              cfg_we;
  logic [RANK_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                idle_cycles;
  int                hold_cycles;
  bit                calm;

  kst_in_if  in_ch ();
  kst_out_if out_ch ();

  kth_largest_stream_tracker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  kst_rank_checker u_rank_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("kth_largest_stream_tracker_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one beat after a random gap and returns at the edge that takes it,
  // with valid still high so that a following beat can go back to back.
  task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic rs);
    int gap;
    gap = calm ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.restart <= rs;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stops offering and waits until every result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_cycles > 0) stall = hold_cycles;
      else stall = calm ? 0 : $urandom_range(16, 0);
      hold_cycles = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    int                      n_items;
    logic                    rs;
    logic signed [VAL_W-1:0] v;
    logic [RANK_W-1:0]       r;
    rst_n         = 1'b0;
    calm          = 1'b0;
    hold_cycles   = 0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Fill a set of four, then displace, drop ties and smaller values.
    write_rank(4);
    send_beat(VAL_MIN, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    send_beat(0, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(5, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(-7, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    send_beat(1, 1'b1);
    drain();

    // A rank of zero behaves as one.
    write_rank(0);
    send_beat(3, 1'b0);
    send_beat(2, 1'b0);
    send_beat(VAL_MIN, 1'b1);
    send_beat(VAL_MAX, 1'b0);
    drain();

    // A rank above the capacity saturates.
    write_rank(7'h7f);
    send_beat(10, 1'b1);
    send_beat(VAL_MIN, 1'b0);
    send_beat(20, 1'b0);
    drain();

    // Rank lowered below the held count: no adds, but displacement goes on.
    write_rank(2);
    send_beat(15, 1'b0);
    send_beat(-100, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(7, 0))
        0:       r = RANK_W'(0);
        1:       r = RANK_W'(1);
        2:       r = RANK_W'(64);
        3:       r = 7'h7f;
        4:       r = RANK_W'($urandom_range(126, 65));
        5:       r = RANK_W'($urandom_range(8, 1));
        default: r = RANK_W'($urandom_range(64, 1));
      endcase
      write_rank(r);
      calm    = (phase == 2) || ($urandom_range(3, 0) == 0);
      n_items = $urandom_range(220, 120);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(7, 0))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2, 3:    v = $urandom_range(40, 0) - 20;
          default: v = $urandom();
        endcase
        if (i == 0) rs = 1'($urandom_range(1, 0));
        else rs = ($urandom_range(49, 0) == 0);
        // The receiver stops for a long while as the sender keeps offering,
        // so the output buffer fills and the input is held back.
        if (phase == 2 && i == 40) hold_cycles = LONG_HOLD;
        if (phase == 5 && i == 60) drain();
        send_beat(v, rs);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("kth_largest_stream_tracker_unit verification clean");
    end else begin
      $display("kth_largest_stream_tracker_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kst_pkg.sv
hw/rtl/kst_in_if.sv
hw/rtl/kst_out_if.sv
hw/rtl/kst_cell.sv
hw/rtl/kth_largest_stream_tracker_unit.sv
tb/kst_rank_checker.sv
tb/kth_largest_stream_tracker_unit_tb.sv
